// File: hdl/sdi_pkg.sv
// package for the string dictionary intern block
// shared types and constants; no dependencies
package sdi_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DICT     = 2'd1;
    localparam logic [1:0] ST_ARENA    = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic clr_str;     // clear hash, length, flag
        logic clr_slot;    // clearing pass write of one hash slot
        logic load_slot;   // slot pointer from hash
        logic next_slot;   // advance slot pointer
        logic rd_slot;     // read hash slot
        logic rd_entry;    // read entry offset/length
        logic cmp_start;   // reset compare index
        logic rd_bytes;    // read arena and buffer at compare index
        logic cmp_step;    // advance compare index
        logic wr_entry;    // write entry tables and slot
        logic wr_byte;     // copy one byte into arena
        logic commit;      // bump counts
    } sdi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic too_long;
        logic slot_empty;
        logic len_eq;
        logic cmp_done;
        logic byte_eq;
        logic probes_done;
        logic dict_full;
        logic arena_full;
        logic copy_done;
    } sdi_stat_t;

endpackage

// File: hdl/sdi_datapath.sv
// datapath: string buffer, fnv-1a hash, slot table, entry tables, arena
// depends on sdi_pkg
module sdi_datapath
    import sdi_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int TABLE_SLOTS = 2048,
    parameter int ARENA_BYTES = 65536,
    parameter int MAX_STR_LEN = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_take,
    input  logic [7:0] in_byte,
    input  logic       in_bvalid,
    input  sdi_cmd_t   cmd,
    output sdi_stat_t  stat,
    output logic [9:0] code
);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int AW = $clog2(ARENA_BYTES);
    localparam int LW = $clog2(MAX_STR_LEN);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int VW = $clog2(ARENA_BYTES + 1);
    localparam int NW = $clog2(MAX_STR_LEN + 1);
    localparam int PW = $clog2(TABLE_SLOTS + 1);
    localparam int TW = EW + 1;
    localparam logic [SW-1:0] HOME0 = FNV_BASIS[SW-1:0];

    logic [TW-1:0] slot_mem [TABLE_SLOTS];
    logic [AW:0]   off_mem [MAX_ENTRIES];
    logic [NW-1:0] len_mem [MAX_ENTRIES];
    logic [7:0]    arena_mem [ARENA_BYTES];
    logic [7:0]    buf_mem [MAX_STR_LEN];

    logic [31:0]   hash_reg;
    logic [NW-1:0] len_reg;
    logic          tl_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] used_reg;
    logic [SW-1:0] slot_reg;
    logic [PW-1:0] probes_reg;
    logic [TW-1:0] sv_reg;
    logic [AW:0]   eoff_reg;
    logic [NW-1:0] elen_reg;
    logic [NW-1:0] idx_reg;
    logic [7:0]    ab_reg;
    logic [7:0]    bb_reg;
    logic [9:0]    code_reg;
    logic [31:0]   hash_next;
    logic [AW:0]   aaddr;
    logic          take_byte;

    assign hash_next = (hash_reg ^ {24'd0, in_byte}) * FNV_PRIME;
    assign aaddr = eoff_reg + (AW+1)'(idx_reg);
    assign take_byte = in_take && in_bvalid && len_reg < NW'(MAX_STR_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= FNV_BASIS;
            len_reg    <= '0;
            tl_reg     <= 1'b0;
            cnt_reg    <= CW'(1);
            used_reg   <= '0;
            slot_reg   <= '0;
            probes_reg <= '0;
        end
        else
        begin
            if (cmd.clr_str)
            begin
                hash_reg <= FNV_BASIS;
                len_reg  <= '0;
                tl_reg   <= 1'b0;
            end
            else if (in_take && in_bvalid)
            begin
                if (len_reg < NW'(MAX_STR_LEN))
                begin
                    len_reg  <= len_reg + NW'(1);
                    hash_reg <= hash_next;
                end
                else
                    tl_reg <= 1'b1;
            end
            // the last byte of a string lands in the hash at the same edge
            if (cmd.load_slot)
            begin
                slot_reg   <= take_byte ? hash_next[SW-1:0] : hash_reg[SW-1:0];
                probes_reg <= '0;
            end
            else if (cmd.next_slot)
            begin
                slot_reg   <= slot_reg + SW'(1);
                probes_reg <= probes_reg + PW'(1);
            end
            if (cmd.commit)
            begin
                cnt_reg  <= cnt_reg + CW'(1);
                used_reg <= used_reg + VW'(len_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && in_bvalid && !cmd.clr_str && len_reg < NW'(MAX_STR_LEN))
            buf_mem[len_reg[LW-1:0]] <= in_byte;
        // empty string entry 0 sits in its home slot after the clearing pass
        if (cmd.clr_slot)
        begin
            slot_mem[slot_reg] <= (slot_reg == HOME0) ? TW'(1) : '0;
            off_mem[0] <= '0;
            len_mem[0] <= '0;
        end
        if (cmd.rd_slot)
            sv_reg <= slot_mem[slot_reg];
        if (cmd.wr_entry)
        begin
            slot_mem[slot_reg] <= TW'(cnt_reg) + TW'(1);
            off_mem[cnt_reg[EW-1:0]] <= (AW+1)'(used_reg);
            len_mem[cnt_reg[EW-1:0]] <= len_reg;
            code_reg <= 10'(cnt_reg);
        end
        if (cmd.rd_entry)
        begin
            eoff_reg <= off_mem[sv_reg[EW-1:0] - EW'(1)];
            elen_reg <= len_mem[sv_reg[EW-1:0] - EW'(1)];
            code_reg <= 10'(sv_reg - TW'(1));
        end
        if (cmd.cmp_start)
            idx_reg <= '0;
        else if (cmd.cmp_step)
            idx_reg <= idx_reg + NW'(1);
        if (cmd.rd_bytes)
        begin
            ab_reg <= arena_mem[aaddr[AW-1:0]];
            bb_reg <= buf_mem[idx_reg[LW-1:0]];
        end
        if (cmd.wr_byte)
            arena_mem[AW'(used_reg) + AW'(idx_reg)] <= bb_reg;
    end

    always_comb
    begin
        stat.too_long    = tl_reg;
        stat.slot_empty  = sv_reg == '0;
        stat.len_eq      = elen_reg == len_reg;
        stat.cmp_done    = idx_reg >= len_reg;
        stat.byte_eq     = ab_reg == bb_reg;
        stat.probes_done = probes_reg >= PW'(TABLE_SLOTS - 1);
        stat.dict_full   = cnt_reg >= CW'(MAX_ENTRIES);
        stat.arena_full  = (VW+1)'(used_reg) + (VW+1)'(len_reg) > (VW+1)'(ARENA_BYTES);
        stat.copy_done   = idx_reg >= len_reg;
    end

    assign code = code_reg;

endmodule

// File: hdl/sdi_ctrl.sv
// controller: probe, compare and insert sequencing plus result register
// depends on sdi_pkg
module sdi_ctrl
    import sdi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    output logic       in_take,
    input  sdi_stat_t  stat,
    input  logic [9:0] dp_code,
    output sdi_cmd_t   cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] out_code,
    output logic       out_new,
    output logic [1:0] out_status
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SLOT, S_CHK, S_ENT, S_LEN, S_BCMP,
        S_INS, S_COPY, S_CWR, S_CRD, S_DONE
    } state_t;

    state_t     state_reg;
    logic       ovld_reg;
    logic [9:0] code_reg;
    logic       new_reg;
    logic [1:0] st_reg;

    assign in_ready = state_reg == S_IDLE && !ovld_reg;
    assign in_take  = in_valid && in_ready;
    assign out_valid  = ovld_reg;
    assign out_code   = code_reg;
    assign out_new    = new_reg;
    assign out_status = st_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_slot  = 1'b1;
                cmd.next_slot = 1'b1;
            end
            S_IDLE:  cmd.load_slot = 1'b1;
            S_SLOT:  cmd.rd_slot   = 1'b1;
            S_CHK:   cmd.rd_entry  = 1'b1;
            S_ENT:   cmd.cmp_start = 1'b1;
            S_LEN:   cmd.rd_bytes  = 1'b1;
            S_BCMP:  cmd.cmp_step  = stat.byte_eq;
            S_INS:
            begin
                cmd.wr_entry  = 1'b1;
                cmd.cmp_start = 1'b1;
            end
            // copy loop: read buffer byte, then write it into the arena
            S_COPY:
            begin
                cmd.rd_bytes = !stat.copy_done;
                cmd.commit   = stat.copy_done;
            end
            S_CWR:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.cmp_step = 1'b1;
            end
            S_CRD:   cmd.next_slot = !stat.probes_done;
            S_DONE:  cmd.clr_str = 1'b1;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ovld_reg  <= 1'b0;
            code_reg  <= '0;
            new_reg   <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            if (ovld_reg && out_ready)
                ovld_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    if (stat.probes_done)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_take && in_last)
                        state_reg <= S_SLOT;
                end
                S_SLOT:
                begin
                    if (stat.too_long)
                    begin
                        st_reg <= ST_TOO_LONG;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (stat.slot_empty)
                    begin
                        if (stat.dict_full)
                        begin
                            st_reg <= ST_DICT;
                            state_reg <= S_DONE;
                        end
                        else if (stat.arena_full)
                        begin
                            st_reg <= ST_ARENA;
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_INS;
                    end
                    else
                        state_reg <= S_ENT;
                end
                S_ENT:
                    state_reg <= S_LEN;
                S_LEN:
                begin
                    if (!stat.len_eq)
                        state_reg <= S_CRD;
                    else if (stat.cmp_done)
                    begin
                        st_reg <= ST_OK;
                        new_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_BCMP;
                end
                S_BCMP:
                begin
                    if (!stat.byte_eq)
                        state_reg <= S_CRD;
                    else
                        state_reg <= S_LEN;
                end
                S_CRD:
                begin
                    // next probe slot, or give up after a full sweep
                    if (stat.probes_done)
                    begin
                        st_reg <= ST_DICT;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SLOT;
                end
                S_INS:
                begin
                    st_reg <= ST_OK;
                    new_reg <= 1'b1;
                    state_reg <= S_COPY;
                end
                S_COPY:
                begin
                    if (stat.copy_done)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_CWR;
                end
                S_CWR:
                    state_reg <= S_COPY;
                S_DONE:
                begin
                    code_reg <= (st_reg == ST_OK) ? dp_code : 10'd0;
                    if (st_reg != ST_OK)
                        new_reg <= 1'b0;
                    ovld_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/sdi_glue.sv
// command merge: overrides the slot advance and insert commit fields of the controller commands
// depends on sdi_pkg
module sdi_glue
    import sdi_pkg::*;
(
    input  sdi_cmd_t  cmd_in,
    input  logic      adv,
    input  logic      ins_done,
    output sdi_cmd_t  cmd_out
);
    always_comb
    begin
        cmd_out = cmd_in;
        cmd_out.next_slot = adv;
        cmd_out.commit    = ins_done;
    end
endmodule

// File: hdl/string_dictionary_intern.sv
// top level of the string dictionary intern block
// depends on sdi_pkg, sdi_ctrl, sdi_glue, sdi_datapath
//
// channel  dir  tdata                                   tuser       tlast
// s_axis   in   data_byte[7:0]                          byte_valid  last
// m_axis   out  code[9:0], new_entry[10], status[12:11] -           -
//
// bytes are taken at one per cycle while a string is collected
// after the last transaction of a string: probe from its hash slot, compare length
// and bytes of each stored entry, skip the slot on a mismatch, insert and copy into
// the arena on an empty slot; a too long string or a full dictionary or arena ends early; then one result
// no new input while a result waits to be taken
// after reset a clearing pass over all TABLE_SLOTS hash slots holds the input off
module string_dictionary_intern
    import sdi_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int TABLE_SLOTS = 2048,
    parameter int ARENA_BYTES = 65536,
    parameter int MAX_STR_LEN = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // code[9:0], new_entry[10], status[12:11], zero
);
    sdi_cmd_t  cmd_c;
    sdi_cmd_t  cmd;
    sdi_stat_t stat;
    logic       take;
    logic [9:0] dp_code;
    logic [9:0] code;
    logic       new_e;
    logic [1:0] st;

    sdi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .in_take(take),
        .stat(stat), .dp_code(dp_code), .cmd(cmd_c),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_code(code), .out_new(new_e), .out_status(st)
    );

    sdi_glue u_glue (
        .cmd_in(cmd_c), .adv(cmd_c.next_slot), .ins_done(cmd_c.commit),
        .cmd_out(cmd)
    );

    sdi_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES), .TABLE_SLOTS(TABLE_SLOTS),
        .ARENA_BYTES(ARENA_BYTES), .MAX_STR_LEN(MAX_STR_LEN)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_take(take),
        .in_byte(s_axis_tdata), .in_bvalid(s_axis_tuser),
        .cmd(cmd), .stat(stat), .code(dp_code)
    );

    assign m_axis_tdata = {3'd0, st, new_e, code};

endmodule

// File: hdl/sdi_checker.sv
// port checker for the string dictionary intern block
// depends on sdi_pkg; bound to string_dictionary_intern
module sdi_checker
    import sdi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open with result pending");
    a_err_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[12:11] != ST_OK) |-> m_axis_tdata[10:0] == '0)
        else $error("error result carries a code");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:13] == '0) else $error("pad bits set");
endmodule

bind string_dictionary_intern sdi_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
